// ----- design/pise_pkg.sv -----
`default_nettype none

package pise_pkg;

  localparam int unsigned PEN_W      = 8;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned MAX_PLANES = 8;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned S_TDATA_W  = 8;
  localparam int unsigned M_TDATA_W  = 40;

  localparam logic [CFG_ADDR_W-1:0] REG_PLANE_PICK   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PLANE_ON_OFF = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PLANE_COUNT  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_X     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Y     = 3'd6;

  localparam logic CMD_MOVE = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  typedef struct packed {
    logic [PEN_W-1:0]   pick;
    logic [PEN_W-1:0]   on_off;
    logic [COUNT_W-1:0] count;
  } pen_cfg_t;

  // packed from the top down, command ends up in the lowest bit
  typedef struct packed {
    logic [PEN_W-1:0] pen;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_x;
    logic             command;
  } result_t;

  typedef struct packed {
    logic    last;
    result_t res;
  } entry_t;

endpackage

`default_nettype wire

// ----- design/pise_pen_map.sv -----
`default_nettype none

module pise_pen_map
  import pise_pkg::*;
(
  input  pen_cfg_t         cfg_i,
  input  logic [PEN_W-1:0] plane_bits_i,
  output logic [PEN_W-1:0] pen_o
);

  logic [COUNT_W-1:0] planes;
  logic [COUNT_W-1:0] src;
  logic [PEN_W-1:0]   pen;

  // stored plane n lands on the n-th set bit of the pick mask
  always_comb begin
    planes = (cfg_i.count > COUNT_W'(MAX_PLANES)) ? COUNT_W'(MAX_PLANES) : cfg_i.count;
    pen    = cfg_i.on_off;
    src    = '0;
    for (int dest = 0; dest < PEN_W; dest++) begin
      if (cfg_i.pick[dest] && (src < planes)) begin
        if (plane_bits_i[src[2:0]]) begin
          pen[dest] = 1'b1;
        end
        src = src + COUNT_W'(1);
      end
    end
  end

  assign pen_o = pen;

endmodule

`default_nettype wire

// ----- design/planar_image_span_encoder.sv -----
`default_nettype none

// path: an item enters an input register, its commands then enter the output queue
// throughput: one item per cycle while items cause at most one command and the master
// side is ready; an item causing two holds the next back while the single result port
// drains the two-entry queue
// reset: asynchronous, active low; configuration registers return to their defaults,
// counters and the previous pen clear, both sides empty

module planar_image_span_encoder
  import pise_pkg::*;
#(
  parameter int unsigned MAX_DIMENSION = 1024
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,

  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,

  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,   // plane_bits[7:0]

  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output      logic [M_TDATA_W-1:0]  m_axis_tdata,   // pen, pos_y, pos_x from msb down
  output      logic                  m_axis_tuser,   // command
  output      logic                  m_axis_tlast
);

  localparam int unsigned CNT_W = $clog2(MAX_DIMENSION);
  localparam int unsigned CMP_W = (CNT_W + 1 > DIM_W + 1) ? CNT_W + 1 : DIM_W + 1;
  localparam logic [CMP_W-1:0] DIM_LIM = CMP_W'(MAX_DIMENSION);

  logic [PEN_W-1:0]   plane_pick_q;
  logic [PEN_W-1:0]   plane_on_off_q;
  logic [COUNT_W-1:0] plane_count_q;
  logic [DIM_W-1:0]   image_width_q;
  logic [DIM_W-1:0]   image_height_q;
  logic [POS_W-1:0]   origin_x_q;
  logic [POS_W-1:0]   origin_y_q;

  logic [CNT_W-1:0]   col_q, col_d;
  logic [CNT_W-1:0]   row_q, row_d;
  logic [PEN_W-1:0]   prev_pen_q;

  logic               in_valid_q;
  logic [PEN_W-1:0]   in_bits_q;

  logic [1:0]         q_cnt_q, q_cnt_d;
  entry_t             q0_q, q0_d;
  entry_t             q1_q, q1_d;

  pen_cfg_t           pen_cfg;
  logic [PEN_W-1:0]   pen;
  logic [CMP_W-1:0]   w_ext, h_ext, w_lim, h_lim;
  logic               row_end, col_first, pen_change, last_row;
  logic               have_a, proc, pop, s_fire;
  result_t            res_a, res_b;
  logic [POS_W-1:0]   pos_x, pos_y;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_pick_q   <= 8'hff;
      plane_on_off_q <= '0;
      plane_count_q  <= COUNT_W'(1);
      image_width_q  <= DIM_W'(16);
      image_height_q <= DIM_W'(16);
      origin_x_q     <= '0;
      origin_y_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_PLANE_PICK:   plane_pick_q   <= cfg_wdata_i[PEN_W-1:0];
        REG_PLANE_ON_OFF: plane_on_off_q <= cfg_wdata_i[PEN_W-1:0];
        REG_PLANE_COUNT:  plane_count_q  <= cfg_wdata_i[COUNT_W-1:0];
        REG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata_i[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height_q <= cfg_wdata_i[DIM_W-1:0];
        REG_ORIGIN_X:     origin_x_q     <= cfg_wdata_i[POS_W-1:0];
        REG_ORIGIN_Y:     origin_y_q     <= cfg_wdata_i[POS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign pen_cfg.pick   = plane_pick_q;
  assign pen_cfg.on_off = plane_on_off_q;
  assign pen_cfg.count  = plane_count_q;

  pise_pen_map u_pen_map (
    .cfg_i        (pen_cfg),
    .plane_bits_i (in_bits_q),
    .pen_o        (pen)
  );

  // dimensions of zero act as one, oversized ones saturate
  assign w_ext = CMP_W'(image_width_q);
  assign h_ext = CMP_W'(image_height_q);
  assign w_lim = (w_ext == '0) ? CMP_W'(1) : ((w_ext > DIM_LIM) ? DIM_LIM : w_ext);
  assign h_lim = (h_ext == '0) ? CMP_W'(1) : ((h_ext > DIM_LIM) ? DIM_LIM : h_ext);

  assign row_end    = (CMP_W'(col_q) + CMP_W'(1)) >= w_lim;
  assign last_row   = (CMP_W'(row_q) + CMP_W'(1)) >= h_lim;
  assign col_first  = (col_q == '0);
  assign pen_change = (pen != prev_pen_q);
  assign have_a     = col_first || pen_change;

  assign pos_x = origin_x_q + POS_W'(col_q);
  assign pos_y = origin_y_q + POS_W'(row_q);

  always_comb begin
    res_a.command = col_first ? CMD_MOVE : CMD_DRAW;
    res_a.pos_x   = pos_x;
    res_a.pos_y   = pos_y;
    res_a.pen     = col_first ? '0 : prev_pen_q;
    res_b.command = CMD_DRAW;
    res_b.pos_x   = pos_x;
    res_b.pos_y   = pos_y;
    res_b.pen     = pen;
  end

  // output queue: q0 drives the port, q1 waits behind it
  assign m_axis_tvalid = (q_cnt_q != 2'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign proc          = in_valid_q && ((q_cnt_q == 2'd0) || ((q_cnt_q == 2'd1) && pop));
  assign s_axis_tready = !in_valid_q || proc;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    q_cnt_d = q_cnt_q;
    q0_d    = q0_q;
    q1_d    = q1_q;
    col_d   = col_q;
    row_d   = row_q;
    if (proc) begin
      if (have_a && row_end) begin
        q0_d    = '{last: 1'b0, res: res_a};
        q1_d    = '{last: 1'b1, res: res_b};
        q_cnt_d = 2'd2;
      end else if (have_a) begin
        q0_d    = '{last: 1'b1, res: res_a};
        q_cnt_d = 2'd1;
      end else if (row_end) begin
        q0_d    = '{last: 1'b1, res: res_b};
        q_cnt_d = 2'd1;
      end else begin
        q_cnt_d = 2'd0;
      end
      if (row_end) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + CNT_W'(1);
      end else begin
        col_d = col_q + CNT_W'(1);
      end
    end else if (pop) begin
      q0_d    = q1_q;
      q_cnt_d = q_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      q_cnt_q    <= 2'd0;
      col_q      <= '0;
      row_q      <= '0;
      prev_pen_q <= '0;
    end else begin
      if (s_fire) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end
      q_cnt_q <= q_cnt_d;
      col_q   <= col_d;
      row_q   <= row_d;
      if (proc) begin
        prev_pen_q <= pen;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_bits_q <= s_axis_tdata;
    end
    q0_q <= q0_d;
    q1_q <= q1_d;
  end

  assign m_axis_tdata = {q0_q.res.pen, q0_q.res.pos_y, q0_q.res.pos_x};
  assign m_axis_tuser = q0_q.res.command;
  assign m_axis_tlast = q0_q.last;

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q != 2'd3)
    else $error("output queue holds more than two entries");

  a_head_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_cnt_q == 2'd2) |-> !q0_q.last)
    else $error("first of two queued commands marked last");

  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && row_end) |=> (col_q == '0))
    else $error("column counter not cleared at row end");

  a_move_pen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (q0_q.res.command == CMD_MOVE)) |-> (q0_q.res.pen == '0))
    else $error("move command carries a pen");

  a_proc_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> (q_cnt_q != 2'd0 || !($past(have_a) || $past(row_end))))
    else $error("commands of an item lost");

endmodule

`default_nettype wire
